// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 4;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUMP_FWD   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DUMP_BWD   = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture the incoming request
        logic exec;     // carry out the captured request
        logic rd_load;  // move read data into the output register
        logic rd_next;  // advance the dump and read the next element
    } t_dq_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic needs_read;  // request is a pop or dump on a non-empty store
        logic more;        // dump has further elements after the current one
    } t_dq_sts;

    // Reduce a sum below twice the capacity to a store index
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(CAPACITY)) ? (s - SUM_W'(CAPACITY)) : s;
        return r[IDX_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/bdq_ram.sv -----
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dq_sts i_sts,
    output t_dq_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Sequence one request at a time
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.needs_read ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_load = 1'b1;
                    if (i_sts.more) begin
                        o_cmd.rd_next = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/bdq_dpath.sv -----
module bdq_dpath
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dq_cmd                  i_cmd,
    output t_dq_sts                  o_sts,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_item,
    output logic                     o_last,
    output logic [OCC_W-1:0]         o_occupancy
);

    // Captured request
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_value;

    // Queue pointers
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic [STAT_W-1:0]        r_status, n_status;
    logic signed [DATA_W-1:0] r_item, n_item;
    logic                     r_last, n_last;
    logic [OCC_W-1:0]         r_occ;
    logic                     load_out;

    // Decode and addressing
    logic             is_push, is_pop, is_dump, backward;
    logic             full, empty, dump_last;
    logic [CNT_W-1:0] off_idx, off;
    logic [IDX_W-1:0] front_inc, front_dec, back_slot, rd_addr, wr_addr;
    logic             ram_we, ram_re;
    logic [DATA_W-1:0] ram_rdata;

    assign is_push  = (r_func == FN_PUSH_FRONT) || (r_func == FN_PUSH_BACK);
    assign is_pop   = (r_func == FN_POP_FRONT)  || (r_func == FN_POP_BACK);
    assign is_dump  = (r_func == FN_DUMP_FWD)   || (r_func == FN_DUMP_BWD);
    assign backward = (r_func == FN_POP_BACK)   || (r_func == FN_DUMP_BWD);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign dump_last = (CNT_W'(r_idx + CNT_W'(1)) == r_count);

    // Offset from the front: element 0 on execute, the next one on advance
    assign off_idx = i_cmd.exec ? '0 : CNT_W'(r_idx + CNT_W'(1));
    assign off     = backward ? CNT_W'(r_count - CNT_W'(1) - off_idx) : off_idx;
    assign rd_addr = wrap_idx(SUM_W'(r_front) + SUM_W'(off));

    assign front_inc = wrap_idx(SUM_W'(r_front) + SUM_W'(1));
    assign front_dec = wrap_idx(SUM_W'(r_front) + SUM_W'(CAPACITY - 1));
    assign back_slot = wrap_idx(SUM_W'(r_front) + SUM_W'(r_count));
    assign wr_addr   = (r_func == FN_PUSH_FRONT) ? front_dec : back_slot;

    assign ram_we = i_cmd.exec && is_push && !full;
    assign ram_re = (i_cmd.exec && (is_pop || is_dump) && !empty) || i_cmd.rd_next;

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Status back to the controller
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_sts.needs_read = (is_pop || is_dump) && !empty;
    assign o_sts.more       = is_dump && !dump_last;

    // Execute the request and build the result
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        load_out = 1'b0;
        n_status = ST_OK;
        n_item   = '0;
        n_last   = 1'b1;
        if (i_cmd.exec) begin
            if (is_push) begin
                load_out = 1'b1;
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_count = CNT_W'(r_count + CNT_W'(1));
                    if (r_func == FN_PUSH_FRONT) begin
                        n_front = front_dec;
                    end
                end
            end else if (is_pop) begin
                if (empty) begin
                    load_out = 1'b1;
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count = CNT_W'(r_count - CNT_W'(1));
                    if (r_func == FN_POP_FRONT) begin
                        n_front = front_inc;
                    end
                end
            end else if (is_dump) begin
                if (empty) begin
                    load_out = 1'b1;
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_idx = '0;
                end
            end else begin
                load_out = 1'b1;
            end
        end else if (i_cmd.rd_load) begin
            load_out = 1'b1;
            n_item   = ram_rdata;
            n_last   = is_pop ? 1'b1 : dump_last;
            if (i_cmd.rd_next) begin
                n_idx = CNT_W'(r_idx + CNT_W'(1));
            end
        end
    end

    // Hold a result until taken
    assign n_out_valid = load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture request, dump index and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        r_idx <= n_idx;
        if (load_out) begin
            r_status <= n_status;
            r_item   <= n_item;
            r_last   <= n_last;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item      = r_item;
    assign o_last      = r_last;
    assign o_occupancy = r_occ;

endmodule

// ----- hw/rtl/bounded_double_ended_queue.sv -----
// Channel   Handshake               Payload
// request   i_in_valid / o_in_stall  i_func, i_value
// result    o_out_valid / i_out_stall o_status, o_item, o_last, o_occupancy
//
// Push, failed pop or dump, and unused codes: accepted, then executed into the output register.
// Pop: executed with a registered read of the element store, then loaded into the output register.
// Dump of n elements: after the first read, one element per cycle while the output register is free.
// A request is taken only when the previous one has finished; a stalled
// result holds in the output register and work waits until it is free.
// Reset clears the front pointer, count and output valid; store contents stay undefined.
module bounded_double_ended_queue
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_item,
    output logic                     o_last,
    output logic [OCC_W-1:0]         o_occupancy
);

    t_dq_cmd cmd;
    t_dq_sts sts;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bdq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_item      (o_item),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

endmodule
